>>> src/sm3_pkg.sv
// SM3 engine package: constants, types, round helper functions.
// No dependencies.
`default_nettype none
package sm3_pkg;
    localparam int unsigned QueueDepth = 4;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // word class handed from front to back
    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_ZERO = 2'd1,
        K_LAST = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0] data;
        t_kind       kind;
    } t_qword;

    typedef enum logic [2:0] {
        S_FILL  = 3'd0,
        S_EXP   = 3'd1,
        S_ROUND = 3'd2,
        S_FOLD  = 3'd3,
        S_EMIT  = 3'd4
    } t_state;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage
`default_nettype wire

>>> src/sm3_if.sv
// Valid/ready channel interfaces for the SM3 engine.
// Depends on nothing.
`default_nettype none
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  bytes_valid;
    logic        is_last;
    modport source (output valid, msg_word, bytes_valid, is_last, input ready);
    modport sink   (input valid, msg_word, bytes_valid, is_last, output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest;
    modport source (output valid, digest_word, word_index, last_digest, input ready);
    modport sink   (input valid, digest_word, word_index, last_digest, output ready);
endinterface
`default_nettype wire

>>> src/sm3_front.sv
// Front end: accepts message words, counts length, emits padded word stream.
// Depends on sm3_pkg.
`default_nettype none
module sm3_front import sm3_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire logic [31:0] i_msg_word,
    input  wire logic [2:0]  i_bytes_valid,
    input  wire logic        i_is_last,
    output logic        o_q_valid,
    input  wire logic   i_q_ready,
    output t_qword      o_q_word
);
    // pad phase: 0 = accept input, 1 = zero fill, 2 = len hi, 3 = len lo
    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_bits, n_bits;
    logic [2:0]  nb;
    logic [63:0] bits_add;
    logic [31:0] keep, padw;
    logic        take;

    assign nb = (i_bytes_valid > 3'd4) ? 3'd4 : i_bytes_valid;
    assign bits_add = i_bits_of(i_is_last, nb);

    function automatic logic [63:0] i_bits_of(input logic l, input logic [2:0] n);
        return l ? {58'd0, n, 3'd0} : 64'd32;
    endfunction

    always_comb begin
        keep = 32'hFFFFFFFF;
        padw = i_msg_word;
        case (nb)
            3'd0: begin keep = 32'h0; padw = {PAD_BYTE, 24'h0}; end
            3'd1: begin keep = 32'hFF000000; padw = (i_msg_word & keep) | {8'h0, PAD_BYTE, 16'h0}; end
            3'd2: begin keep = 32'hFFFF0000; padw = (i_msg_word & keep) | {16'h0, PAD_BYTE, 8'h0}; end
            3'd3: begin keep = 32'hFFFFFF00; padw = (i_msg_word & keep) | {24'h0, PAD_BYTE}; end
            default: padw = i_msg_word;
        endcase
    end

    // a full last word needs two queue slots: it is taken as data, then a pad word follows
    logic r_pend, n_pend;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_bits = r_bits; n_pend = r_pend;
        o_ready = 1'b0; o_q_valid = 1'b0; take = 1'b0;
        o_q_word = '{data: 32'h0, kind: K_ZERO};
        case (r_phase)
            2'd0: begin
                if (r_pend) begin
                    o_q_valid = 1'b1;
                    o_q_word = '{data: {PAD_BYTE, 24'h0}, kind: K_DATA};
                    if (i_q_ready) begin
                        n_pend = 1'b0; n_cnt = r_cnt + 4'd1;
                        n_phase = 2'd1;
                    end
                end else begin
                    o_ready = i_q_ready;
                    o_q_valid = i_valid;
                    o_q_word = '{data: (i_is_last && nb != 3'd4) ? padw : i_msg_word,
                                 kind: K_DATA};
                    take = i_valid && i_q_ready;
                    if (take) begin
                        n_bits = r_bits + bits_add;
                        n_cnt = r_cnt + 4'd1;
                        if (i_is_last) begin
                            if (nb == 3'd4) n_pend = 1'b1;
                            else n_phase = 2'd1;
                        end
                    end
                end
            end
            2'd1: begin
                if (r_cnt == 4'd14) begin
                    n_phase = 2'd2;
                end else begin
                    o_q_valid = 1'b1;
                    if (i_q_ready) n_cnt = r_cnt + 4'd1;
                end
            end
            2'd2: begin
                o_q_valid = 1'b1;
                o_q_word = '{data: r_bits[63:32], kind: K_DATA};
                if (i_q_ready) begin n_cnt = r_cnt + 4'd1; n_phase = 2'd3; end
            end
            default: begin
                o_q_valid = 1'b1;
                o_q_word = '{data: r_bits[31:0], kind: K_LAST};
                if (i_q_ready) begin
                    n_cnt = 4'd0; n_phase = 2'd0; n_bits = 64'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0; r_cnt <= 4'd0; r_bits <= 64'd0; r_pend <= 1'b0;
        end else begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_bits <= n_bits; r_pend <= n_pend;
        end
    end
endmodule
`default_nettype wire

>>> src/sm3_queue.sv
// Small FIFO between front and back ends.
// Depends on sm3_pkg.
`default_nettype none
module sm3_queue import sm3_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_qword    i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_qword    o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_qword r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= inc(r_wp);
            if (rd) r_rp <= inc(r_rp);
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

>>> src/sm3_back.sv
// Back end: block buffer, message expansion window, 64-round compression, digest output.
// Depends on sm3_pkg.
`default_nettype none
module sm3_back import sm3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    output logic      o_q_ready,
    input  t_qword    i_q_word,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest
);
    t_state r_state, n_state;
    logic [31:0] r_cv [8];
    logic [31:0] r_w  [16];
    logic [31:0] r_r  [8];
    logic [3:0]  r_wib;
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic [2:0]  r_oidx;

    logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
    logic push;

    assign o_q_ready = (r_state == S_FILL);
    assign push = i_q_valid && o_q_ready;

    always_comb begin
        t   = (r_rnd < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(r_r[0], 5'd12);
        ss1 = rotl(a12 + r_r[4] + rotl(t, r_rnd[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_rnd < 6'd16) begin
            ff = r_r[0] ^ r_r[1] ^ r_r[2];
            gg = r_r[4] ^ r_r[5] ^ r_r[6];
        end else begin
            ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
            gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
        end
        tt1 = ff + r_r[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_r[7] + ss1 + r_w[0];
        wnew = p1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15)) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL:  if (push && r_wib == 4'd15) n_state = S_ROUND;
            S_ROUND: if (r_rnd == 6'd63) n_state = S_FOLD;
            S_FOLD:  n_state = r_fin ? S_EMIT : S_FILL;
            S_EMIT:  if (i_ready && r_oidx == 3'd7) n_state = S_FILL;
            default: n_state = S_FILL;
        endcase
    end

    assign o_valid = (r_state == S_EMIT);
    assign o_digest_word = r_cv[r_oidx];
    assign o_word_index = r_oidx;
    assign o_last_digest = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL; r_wib <= 4'd0; r_rnd <= 6'd0; r_fin <= 1'b0; r_oidx <= 3'd0;
            for (int k = 0; k < 8; k++) r_cv[k] <= IV[k];
        end else begin
            r_state <= n_state;
            case (r_state)
                S_FILL: if (push) begin
                    r_w[r_wib] <= i_q_word.data;
                    r_wib <= r_wib + 4'd1;
                    if (r_wib == 4'd15) begin
                        r_fin <= (i_q_word.kind == K_LAST);
                        for (int k = 0; k < 8; k++) r_r[k] <= r_cv[k];
                    end
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                    r_w[15] <= wnew;
                    r_r[3] <= r_r[2]; r_r[2] <= rotl(r_r[1], 5'd9);
                    r_r[1] <= r_r[0]; r_r[0] <= tt1;
                    r_r[7] <= r_r[6]; r_r[6] <= rotl(r_r[5], 5'd19);
                    r_r[5] <= r_r[4]; r_r[4] <= p0(tt2);
                end
                S_FOLD: begin
                    r_rnd <= 6'd0;
                    for (int k = 0; k < 8; k++) r_cv[k] <= r_cv[k] ^ r_r[k];
                end
                S_EMIT: if (i_ready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_fin <= 1'b0;
                        for (int k = 0; k < 8; k++) r_cv[k] <= IV[k];
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rnd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_rnd == 6'd0 || r_state == S_FOLD))
        else $error("round counter not parked");
    a_emit_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_fin) else $error("emit without final block");
    a_fill_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> (r_wib == 4'd0)) else $error("block count off");
`endif
endmodule
`default_nettype wire

>>> src/sm3_hash_engine.sv
// SM3 hash engine top: front end, word queue and compression back end.
// A 16-word block passes through fill, 64 rounds and a fold into the chaining value;
// further message words wait in the queue while the single shared round unit is busy.
// Final word: padding words up to 18 more, then 8 digest transactions.
// Reset is synchronous, active low; it restores the IV and clears all counters.
`default_nettype none
module sm3_hash_engine import sm3_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sm3_in_if.sink    i_in,
    sm3_out_if.source o_out
);
    logic   fq_valid, fq_ready, qb_valid, qb_ready;
    t_qword fq_word, qb_word;

    sm3_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_msg_word(i_in.msg_word), .i_bytes_valid(i_in.bytes_valid),
        .i_is_last(i_in.is_last),
        .o_q_valid(fq_valid), .i_q_ready(fq_ready), .o_q_word(fq_word)
    );

    sm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(fq_valid), .o_ready(fq_ready), .i_data(fq_word),
        .o_valid(qb_valid), .i_ready(qb_ready), .o_data(qb_word)
    );

    sm3_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(qb_valid), .o_q_ready(qb_ready), .i_q_word(qb_word),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_digest_word(o_out.digest_word), .o_word_index(o_out.word_index),
        .o_last_digest(o_out.last_digest)
    );
endmodule
`default_nettype wire
